/* rtl/prototype_match_classifier_macros.svh */
// Assertion macros for the prototype match classifier checker.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef PROTOTYPE_MATCH_CLASSIFIER_MACROS_SVH
`define PROTOTYPE_MATCH_CLASSIFIER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent this cycle implies consequent on the next cycle.
`define PMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pmc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and constant functions of the prototype match classifier.
// No dependencies.
package pmc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 48;
    localparam int D_W        = 28;   // Q.16 distance, unsaturated
    localparam int SCORE_W    = 56;   // exp(Q0.40) * prior(Q2.14)
    localparam int Q40_W      = 41;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [14:0] W_SPEED     = 15'd29491;
    localparam logic [14:0] W_RCS       = 15'd22938;
    localparam logic [13:0] W_JAM       = 14'd13107;
    localparam logic [15:0] MIN_SSPREAD = 16'd16;
    localparam logic [15:0] MIN_RSPREAD = 16'd26;
    localparam logic [15:0] MIN_PRIOR   = 16'd164;
    localparam logic [14:0] SUM_EPS     = 15'd18014;

    typedef struct packed {
        logic [7:0]  class_id;
        logic [15:0] speed;
        logic [15:0] rcs;
        logic        jamming;
        logic [15:0] speed_spread;
        logic [15:0] rcs_spread;
        logic [15:0] prior;
    } entry_t;

    // exp(-1) in Q0.40 from the same 16-term series used at run time
    function automatic logic [40:0] exp_one();
        logic [40:0] term;
        logic [41:0] pos;
        logic [41:0] neg;
        term = {1'b1, 40'd0};
        pos  = {1'b0, term};
        neg  = '0;
        for (int n = 1; n <= 16; n++)
        begin
            term = term / 41'(n);
            if ((n & 1) == 1)
                neg = neg + 42'(term);
            else
                pos = pos + 42'(term);
        end
        return 41'(pos - neg);
    endfunction

    localparam logic [40:0] E1_Q40 = exp_one();

    // Power-up contents of a slot
    function automatic entry_t default_entry(input logic [7:0] idx);
        entry_t e;
        e = '0;
        unique case (idx)
            8'd0: e = '{class_id: 8'd1, speed: 16'd12480, rcs: 16'd717, jamming: 1'b1,
                        speed_spread: 16'd2880, rcs_spread: 16'd282, prior: 16'd16384};
            8'd1: e = '{class_id: 8'd2, speed: 16'd2880, rcs: 16'd282, jamming: 1'b0,
                        speed_spread: 16'd2240, rcs_spread: 16'd230, prior: 16'd16384};
            8'd2: e = '{class_id: 8'd3, speed: 16'd640, rcs: 16'd102, jamming: 1'b0,
                        speed_spread: 16'd1920, rcs_spread: 16'd205, prior: 16'd13107};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

/* rtl/pmc_div.sv */
`timescale 1ns / 1ps
// Iterative restoring divider, STEP quotient bits per cycle.
// Depends on nothing.
module pmc_div #(
    parameter int NW   = 31,
    parameter int DW   = 16,
    parameter int STEP = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int ITERS = (NW + STEP - 1) / STEP;
    localparam int PW    = ITERS * STEP;
    localparam int CW    = $clog2(ITERS + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [PW-1:0] quo_reg;
    logic [PW-1:0] quo_next;
    logic [DW-1:0] div_reg;

    always_comb
    begin
        logic [DW:0] t;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int j = 0; j < STEP; j++)
        begin
            t        = {rem_next, quo_next[PW-1]};
            quo_next = {quo_next[PW-2:0], 1'b0};
            if (t >= {1'b0, div_reg})
            begin
                rem_next    = DW'(t - {1'b0, div_reg});
                quo_next[0] = 1'b1;
            end
            else
                rem_next = t[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= PW'(dividend);
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[NW-1:0];

endmodule

/* rtl/pmc_table.sv */
`timescale 1ns / 1ps
// Prototype table: one synchronous RAM with a registered read port.
// Slots never written read back as their power-up contents. Uses pmc_pkg.
module pmc_table #(
    parameter int DEPTH = pmc_pkg::MAX_ENTRIES_DEF,
    parameter int IDX_W = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  pmc_pkg::entry_t     wdata,
    input  logic                re,
    input  logic [IDX_W-1:0]    raddr,
    output pmc_pkg::entry_t     rdata
);
    pmc_pkg::entry_t mem [DEPTH];
    pmc_pkg::entry_t rd_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
        begin
            rd_reg     <= mem[raddr];
            rd_idx_reg <= raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
                valid_reg[waddr] <= 1'b1;
            if (re)
                rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : pmc_pkg::default_entry(8'(rd_idx_reg));

endmodule

/* rtl/pmc_exp.sv */
`timescale 1ns / 1ps
// Score unit: exp(-d) in Q0.40 by series and repeated exp(-1) products, times prior.
// One shared 21x20 multiplier plus a small divider. Uses pmc_pkg and pmc_div.
module pmc_exp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pmc_pkg::D_W-1:0]      d,
    input  logic [15:0]                  prior,
    output logic                         done,
    output logic [pmc_pkg::SCORE_W-1:0]  score
);
    localparam int K_W = pmc_pkg::D_W - 16;

    localparam logic [3:0] E_IDLE = 4'd0;
    localparam logic [3:0] E_M1   = 4'd1;
    localparam logic [3:0] E_M2   = 4'd2;
    localparam logic [3:0] E_DIV  = 4'd3;
    localparam logic [3:0] E_FIN  = 4'd4;
    localparam logic [3:0] E_INT  = 4'd5;
    localparam logic [3:0] E_P0   = 4'd6;
    localparam logic [3:0] E_P1   = 4'd7;
    localparam logic [3:0] E_P2   = 4'd8;
    localparam logic [3:0] E_P3   = 4'd9;
    localparam logic [3:0] E_S0   = 4'd10;
    localparam logic [3:0] E_S1   = 4'd11;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic        done_reg;
    logic        done_next;

    logic [15:0] f_reg;
    logic [K_W-1:0] k_reg;
    logic [4:0]  n_reg;
    logic [40:0] term_reg;
    logic [41:0] pos_reg;
    logic [41:0] neg_reg;
    logic [40:0] v_reg;
    logic [61:0] acc_reg;
    logic [15:0] prior_reg;
    logic [pmc_pkg::SCORE_W-1:0] score_reg;

    logic [20:0] mul_a;
    logic [19:0] mul_b;
    logic [40:0] mul_p;
    logic [40:0] series_x;
    logic        div_done;
    logic [40:0] div_q;
    logic        series_end;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            E_M1:
            begin
                mul_a = term_reg[40:20];
                mul_b = {4'd0, f_reg};
            end
            E_M2:
            begin
                mul_a = {1'b0, term_reg[19:0]};
                mul_b = {4'd0, f_reg};
            end
            E_P0:
            begin
                mul_a = v_reg[40:20];
                mul_b = {1'b0, pmc_pkg::E1_Q40[38:20]};
            end
            E_P1:
            begin
                mul_a = v_reg[40:20];
                mul_b = pmc_pkg::E1_Q40[19:0];
            end
            E_P2:
            begin
                mul_a = {1'b0, v_reg[19:0]};
                mul_b = {1'b0, pmc_pkg::E1_Q40[38:20]};
            end
            E_P3:
            begin
                mul_a = {1'b0, v_reg[19:0]};
                mul_b = pmc_pkg::E1_Q40[19:0];
            end
            E_S0:
            begin
                mul_a = v_reg[40:20];
                mul_b = {4'd0, prior_reg};
            end
            E_S1:
            begin
                mul_a = {1'b0, v_reg[19:0]};
                mul_b = {4'd0, prior_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    // floor(term * f / 65536); the divide by n follows in the divider
    assign series_x = 41'((acc_reg + 62'(mul_p)) >> 16);

    pmc_div #(
        .NW   (41),
        .DW   (5),
        .STEP (8)
    ) u_div_n (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == E_M2),
        .dividend (series_x),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign series_end = (n_reg == 5'd16) || (div_q == '0);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            E_IDLE: if (start) state_next = E_M1;
            E_M1:   state_next = E_M2;
            E_M2:   state_next = E_DIV;
            E_DIV:  if (div_done) state_next = series_end ? E_FIN : E_M1;
            E_FIN:  state_next = E_INT;
            E_INT:  state_next = (k_reg == '0 || v_reg == '0) ? E_S0 : E_P0;
            E_P0:   state_next = E_P1;
            E_P1:   state_next = E_P2;
            E_P2:   state_next = E_P3;
            E_P3:   state_next = E_INT;
            E_S0:   state_next = E_S1;
            E_S1:
            begin
                state_next = E_IDLE;
                done_next  = 1'b1;
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    f_reg     <= d[15:0];
                    k_reg     <= d[pmc_pkg::D_W-1:16];
                    n_reg     <= 5'd1;
                    term_reg  <= {1'b1, 40'd0};
                    pos_reg   <= {2'b01, 40'd0};
                    neg_reg   <= '0;
                    prior_reg <= prior;
                end
            end
            E_M1: acc_reg <= 62'(mul_p) << 20;
            E_DIV:
            begin
                if (div_done)
                begin
                    term_reg <= div_q;
                    if (n_reg[0])
                        neg_reg <= neg_reg + 42'(div_q);
                    else
                        pos_reg <= pos_reg + 42'(div_q);
                    n_reg <= n_reg + 1'b1;
                end
            end
            E_FIN: v_reg <= (pos_reg > neg_reg) ? 41'(pos_reg - neg_reg) : '0;
            E_P0:  acc_reg <= 62'(mul_p) << 20;
            E_P1:  acc_reg <= acc_reg + 62'(mul_p);
            E_P2:  acc_reg <= acc_reg + 62'(mul_p);
            E_P3:
            begin
                v_reg <= 41'((acc_reg + 62'(mul_p >> 20)) >> 20);
                k_reg <= k_reg - 1'b1;
            end
            E_S0:  acc_reg <= 62'(mul_p) << 20;
            E_S1:  score_reg <= pmc_pkg::SCORE_W'(acc_reg + 62'(mul_p));
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign score = score_reg;

endmodule

/* rtl/prototype_match_classifier.sv */
`timescale 1ns / 1ps
// Top level of the prototype match classifier: stream ports, query sequencer, score sum.
// Uses pmc_pkg, pmc_table, pmc_div and pmc_exp.
//
// Keeps up to MAX_ENTRIES target prototypes in a RAM (three built-in entries after reset) and
// answers a query with the best scoring entry's class, its share of the total score and its
// distance, or with a not-found result when no entries are active or the total score is too
// small. A load item (tuser = 0) is written to the table as it is taken and gives no result. A
// query item (tuser = 1) walks the entries one at a time; per entry the two distance dividers
// run side by side, then the score unit sums the series terms (up to 16, fewer once a term
// reaches zero), multiplies by exp(-1) once per unit of the distance's integer part until the
// value underflows, and multiplies by the prior. After the walk the sum is normalized and a
// serial divider forms the probability. A finished result waits in an output register, and a
// new item is taken while it waits. The user must write record_count through cfg_we /
// cfg_wdata only while the block is idle; the block itself does not enforce it.
module prototype_match_classifier #(
    parameter int MAX_ENTRIES = pmc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // entry_index[3:0], class_id[11:4], speed[27:12], rcs[43:28], jamming[44],
    // speed_spread[60:45], rcs_spread[76:61], prior_weight[92:77], zero pad
    input  logic [pmc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // matched_class[7:0], probability[23:8], distance[47:24]
    output logic [pmc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // found
    output logic                            m_axis_tuser,
    input  logic                            cfg_we,
    input  logic [4:0]                      cfg_wdata
);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W = pmc_pkg::SCORE_W + CNT_W;
    localparam int NORM_W = 47;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_READ     = 4'd1;
    localparam logic [3:0] ST_DIFF     = 4'd2;
    localparam logic [3:0] ST_DIVGO    = 4'd3;
    localparam logic [3:0] ST_DIVWAIT  = 4'd4;
    localparam logic [3:0] ST_EXPGO    = 4'd5;
    localparam logic [3:0] ST_EXPWAIT  = 4'd6;
    localparam logic [3:0] ST_CHECK    = 4'd7;
    localparam logic [3:0] ST_NORM     = 4'd8;
    localparam logic [3:0] ST_PDIVGO   = 4'd9;
    localparam logic [3:0] ST_PDIVWAIT = 4'd10;
    localparam logic [3:0] ST_OUT      = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [4:0] record_count_reg;

    // input fields
    logic [3:0]  in_index;
    logic [7:0]  in_class;
    logic [15:0] in_speed;
    logic [15:0] in_rcs;
    logic        in_jam;
    logic [15:0] in_sspread;
    logic [15:0] in_rspread;
    logic [15:0] in_prior;
    logic        in_accept;
    logic        load_ok;
    logic        query_go;
    logic [CNT_W-1:0] n_eff;

    pmc_pkg::entry_t tbl_wdata;
    pmc_pkg::entry_t tbl_rdata;

    // per-entry work
    logic [15:0] e_ss;
    logic [15:0] e_rs;
    logic [15:0] e_ds;
    logic [15:0] e_dr;
    logic [30:0] e_prod_s;
    logic [30:0] e_prod_r;
    logic [30:0] qs;
    logic [30:0] qr;
    logic        div_s_done;
    logic        div_r_done;
    logic [31:0] d_wide;
    logic        exp_done;
    logic [pmc_pkg::SCORE_W-1:0] exp_score;
    logic        last_entry;
    logic        take_best;

    logic [62:0] pq;
    logic        pdiv_done;
    logic        out_free;

    // payload registers
    logic [15:0] q_speed_reg;
    logic [15:0] q_rcs_reg;
    logic        q_jam_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [30:0] prod_s_reg;
    logic [30:0] prod_r_reg;
    logic [15:0] ss_reg;
    logic [15:0] rs_reg;
    logic        jam_diff_reg;
    logic [15:0] prior_reg;
    logic [7:0]  cur_class_reg;
    logic [pmc_pkg::D_W-1:0] d_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [pmc_pkg::SCORE_W-1:0] best_reg;
    logic [pmc_pkg::D_W-1:0] best_dist_reg;
    logic [7:0]  best_class_reg;
    logic [15:0] prob_reg;
    logic        found_reg;

    logic                           m_valid_reg;
    logic [pmc_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic                           m_user_reg;

    assign in_index   = s_axis_tdata[3:0];
    assign in_class   = s_axis_tdata[11:4];
    assign in_speed   = s_axis_tdata[27:12];
    assign in_rcs     = s_axis_tdata[43:28];
    assign in_jam     = s_axis_tdata[44];
    assign in_sspread = s_axis_tdata[60:45];
    assign in_rspread = s_axis_tdata[76:61];
    assign in_prior   = s_axis_tdata[92:77];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign load_ok       = in_accept && (s_axis_tuser == pmc_pkg::OP_LOAD)
                           && (9'(in_index) < 9'(MAX_ENTRIES));
    assign query_go      = in_accept && (s_axis_tuser == pmc_pkg::OP_QUERY);
    assign n_eff         = (9'(record_count_reg) > 9'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                                    : CNT_W'(record_count_reg);

    always_comb
    begin
        tbl_wdata.class_id     = in_class;
        tbl_wdata.speed        = in_speed;
        tbl_wdata.rcs          = in_rcs;
        tbl_wdata.jamming      = in_jam;
        tbl_wdata.speed_spread = (in_sspread < pmc_pkg::MIN_SSPREAD) ? pmc_pkg::MIN_SSPREAD
                                                                     : in_sspread;
        tbl_wdata.rcs_spread   = (in_rspread < pmc_pkg::MIN_RSPREAD) ? pmc_pkg::MIN_RSPREAD
                                                                     : in_rspread;
        tbl_wdata.prior        = (in_prior < pmc_pkg::MIN_PRIOR) ? pmc_pkg::MIN_PRIOR : in_prior;
    end

    pmc_table #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (load_ok),
        .waddr (IDX_W'(in_index)),
        .wdata (tbl_wdata),
        .re    (state_reg == ST_READ),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (tbl_rdata)
    );

    // power-up zero slots still need the spread floors
    assign e_ss = (tbl_rdata.speed_spread < pmc_pkg::MIN_SSPREAD) ? pmc_pkg::MIN_SSPREAD
                                                                  : tbl_rdata.speed_spread;
    assign e_rs = (tbl_rdata.rcs_spread < pmc_pkg::MIN_RSPREAD) ? pmc_pkg::MIN_RSPREAD
                                                                : tbl_rdata.rcs_spread;
    assign e_ds = (q_speed_reg >= tbl_rdata.speed) ? q_speed_reg - tbl_rdata.speed
                                                   : tbl_rdata.speed - q_speed_reg;
    assign e_dr = (q_rcs_reg >= tbl_rdata.rcs) ? q_rcs_reg - tbl_rdata.rcs
                                               : tbl_rdata.rcs - q_rcs_reg;
    assign e_prod_s = e_ds * pmc_pkg::W_SPEED;
    assign e_prod_r = e_dr * pmc_pkg::W_RCS;

    pmc_div #(
        .NW   (31),
        .DW   (16),
        .STEP (1)
    ) u_div_s (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIVGO),
        .dividend (prod_s_reg),
        .divisor  (ss_reg),
        .done     (div_s_done),
        .quotient (qs)
    );

    pmc_div #(
        .NW   (31),
        .DW   (16),
        .STEP (1)
    ) u_div_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIVGO),
        .dividend (prod_r_reg),
        .divisor  (rs_reg),
        .done     (div_r_done),
        .quotient (qr)
    );

    assign d_wide = 32'(qs) + 32'(qr) + (jam_diff_reg ? 32'(pmc_pkg::W_JAM) : 32'd0);

    pmc_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_EXPGO),
        .d     (d_reg),
        .prior (prior_reg),
        .done  (exp_done),
        .score (exp_score)
    );

    assign last_entry = (CNT_W'(idx_reg + 1'b1) == n_reg);
    assign take_best  = (idx_reg == '0) || (exp_score > best_reg);

    pmc_div #(
        .NW   (NORM_W + 16),
        .DW   (NORM_W),
        .STEP (1)
    ) u_div_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_PDIVGO),
        .dividend ({best_reg[NORM_W-1:0], 16'd0}),
        .divisor  (sum_reg[NORM_W-1:0]),
        .done     (pdiv_done),
        .quotient (pq)
    );

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (query_go)
                    state_next = (n_eff == '0) ? ST_OUT : ST_READ;
            ST_READ:     state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_DIVGO;
            ST_DIVGO:    state_next = ST_DIVWAIT;
            ST_DIVWAIT:  if (div_s_done && div_r_done) state_next = ST_EXPGO;
            ST_EXPGO:    state_next = ST_EXPWAIT;
            ST_EXPWAIT:  if (exp_done) state_next = last_entry ? ST_CHECK : ST_READ;
            ST_CHECK:
                state_next = (sum_reg <= SUM_W'(pmc_pkg::SUM_EPS)) ? ST_OUT : ST_NORM;
            ST_NORM:     if (sum_reg[SUM_W-1:NORM_W] == '0) state_next = ST_PDIVGO;
            ST_PDIVGO:   state_next = ST_PDIVWAIT;
            ST_PDIVWAIT: if (pdiv_done) state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            record_count_reg <= 5'd3;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                record_count_reg <= cfg_wdata;
            if (state_reg == ST_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    q_speed_reg <= in_speed;
                    q_rcs_reg   <= in_rcs;
                    q_jam_reg   <= in_jam;
                    n_reg       <= n_eff;
                    idx_reg     <= '0;
                    sum_reg     <= '0;
                    found_reg   <= 1'b0;
                end
            end
            ST_DIFF:
            begin
                prod_s_reg    <= e_prod_s;
                prod_r_reg    <= e_prod_r;
                ss_reg        <= e_ss;
                rs_reg        <= e_rs;
                jam_diff_reg  <= (q_jam_reg != tbl_rdata.jamming);
                prior_reg     <= tbl_rdata.prior;
                cur_class_reg <= tbl_rdata.class_id;
            end
            ST_DIVWAIT:
                if (div_s_done && div_r_done)
                    d_reg <= d_wide[pmc_pkg::D_W-1:0];
            ST_EXPWAIT:
            begin
                if (exp_done)
                begin
                    sum_reg <= sum_reg + SUM_W'(exp_score);
                    if (take_best)
                    begin
                        best_reg       <= exp_score;
                        best_dist_reg  <= d_reg;
                        best_class_reg <= cur_class_reg;
                    end
                    idx_reg <= CNT_W'(idx_reg + 1'b1);
                end
            end
            ST_NORM:
            begin
                if (sum_reg[SUM_W-1:NORM_W] != '0)
                begin
                    sum_reg  <= sum_reg >> 1;
                    best_reg <= best_reg >> 1;
                end
            end
            ST_PDIVWAIT:
            begin
                if (pdiv_done)
                begin
                    prob_reg  <= (pq[62:16] != '0) ? 16'hFFFF : pq[15:0];
                    found_reg <= 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_user_reg <= found_reg;
                    if (found_reg)
                        m_data_reg <= {(best_dist_reg[pmc_pkg::D_W-1:24] != '0)
                                           ? 24'hFFFFFF : best_dist_reg[23:0],
                                       prob_reg, best_class_reg};
                    else
                        m_data_reg <= '0;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

/* rtl/pmc_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the prototype match classifier, bound to the top level.
// Uses pmc_pkg and prototype_match_classifier_macros.svh.
`include "prototype_match_classifier_macros.svh"

module pmc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pmc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser
);
    // stalled result holds
    `PMC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // a not-found result carries all zero fields
    `PMC_ASSERT(a_nf_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "not-found result has nonzero fields")

    // a found result has a nonzero probability; the best entry holds at least an even share of the sum
    `PMC_ASSERT(a_prob_nz, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:8] != 16'd0, "found result with zero probability")

    // a query occupies the block
    `PMC_ASSERT_NEXT(a_query_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == pmc_pkg::OP_QUERY, !s_axis_tready, "input taken during a query")

endmodule

bind prototype_match_classifier pmc_checker u_pmc_checker (.*);
